/* design/pam_pkg.sv */
// Shared types and constants for the polynomial add/multiply core.
// Holds the opcode codes, the command word carried from front to back and the back-end states.
// Depends on nothing.
package pam_pkg;

	localparam int COEF_W      = 16;
	localparam int RES_W       = 48;
	localparam int PROD_W      = 32;
	localparam int SUM_W       = 17;
	localparam int POW_W       = 5;
	localparam int RPOW_W      = 6;
	localparam int OP_W        = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [OP_W-1:0] OP_CLR_A = 3'd0;
	localparam logic [OP_W-1:0] OP_CLR_B = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_A  = 3'd2;
	localparam logic [OP_W-1:0] OP_WR_B  = 3'd3;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd4;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd5;

	typedef enum logic [2:0] {
		CMD_CLR_A,
		CMD_CLR_B,
		CMD_WR_A,
		CMD_WR_B,
		CMD_ADD,
		CMD_MUL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [POW_W-1:0]          power;
		logic signed [COEF_W-1:0]  coef;
	} cmd_word_t;

	typedef struct packed {
		logic      valid;
		cmd_word_t word;
	} cmd_push_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

/* design/polynomial_add_multiply_core.sv */
// Top level of the polynomial add/multiply core.
// Joins front end, command queue and back end. Depends on pam_pkg, pam_front, pam_queue, pam_back.
//
// Use: input words (opcode, term_power, term_coef) arrive on item_valid/item_stall; result words
// (result_power, result_coef, last_term) leave on result_valid/result_stall. A word moves at a
// rising edge with valid high and stall low.
// Clear and write words give no result; writes beyond NUM_TERMS-1 and unused opcodes are
// dropped in the front end. Add gives NUM_TERMS results, multiply 2*NUM_TERMS-1, in order of
// power and one per cycle while result_stall is low, the last flagged by last_term. The first
// result passes the front-end command register, the queue, the back-end dispatch, the stage-1
// registers and the result register. A multiply holds the back end through dispatch and the
// issue of its results through a row of NUM_TERMS multipliers; an add holds it likewise.
// A stall on the result side holds a running add or multiply; the front end and the four-word
// queue hold up to five waiting words, and item_stall rises when both are full.
// Reset clears A and B to zero and empties the queue and pipeline.
module polynomial_add_multiply_core import pam_pkg::*; #(
	parameter int NUM_TERMS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [OP_W-1:0]         opcode,
	input  logic [POW_W-1:0]        term_power,
	input  logic signed [COEF_W-1:0] term_coef,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [RPOW_W-1:0]       result_power,
	output logic signed [RES_W-1:0] result_coef,
	output logic                    last_term
);

	cmd_push_t push;
	logic      queue_full;
	logic      cmd_pop;
	logic      cmd_valid;
	cmd_word_t cmd_word;

	pam_front #(.NUM_TERMS(NUM_TERMS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.term_power (term_power),
		.term_coef  (term_coef),
		.push       (push),
		.queue_full (queue_full)
	);

	pam_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.pop        (cmd_pop),
		.head_valid (cmd_valid),
		.head       (cmd_word)
	);

	pam_back #(.NUM_TERMS(NUM_TERMS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_word     (cmd_word),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_power (result_power),
		.result_coef  (result_coef),
		.last_term    (last_term)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_last_power: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_term) |->
		(result_power == RPOW_W'(NUM_TERMS - 1) || result_power == RPOW_W'(2 * NUM_TERMS - 2)))
		else $error("last word at wrong power");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !last_term) |=>
		(result_valid && result_power == $past(result_power) + 1'b1))
		else $error("result run broken");

endmodule

/* design/pam_front.sv */
// Front end: accepts input words, decodes the opcode and drops words with no effect.
// Holds one decoded command word until the queue takes it. Depends on pam_pkg.
module pam_front import pam_pkg::*; #(
	parameter int NUM_TERMS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [OP_W-1:0]          opcode,
	input  logic [POW_W-1:0]         term_power,
	input  logic signed [COEF_W-1:0] term_coef,
	output cmd_push_t                push,
	input  logic                     queue_full
);

	logic      cmd_valid_q;
	cmd_word_t cmd_word_q;
	logic      keep;
	cmd_kind_t kind;
	logic      in_range;

	assign in_range = ({1'b0, term_power} < RPOW_W'(NUM_TERMS));

	always_comb begin
		keep = 1'b1;
		kind = CMD_CLR_A;
		case (opcode)
			OP_CLR_A: kind = CMD_CLR_A;
			OP_CLR_B: kind = CMD_CLR_B;
			OP_WR_A: begin
				kind = CMD_WR_A;
				keep = in_range;
			end
			OP_WR_B: begin
				kind = CMD_WR_B;
				keep = in_range;
			end
			OP_ADD: kind = CMD_ADD;
			OP_MUL: kind = CMD_MUL;
			default: keep = 1'b0;
		endcase
	end

	assign item_stall = cmd_valid_q && queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (!item_stall) begin
			cmd_valid_q <= item_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_word_q.kind  <= kind;
			cmd_word_q.power <= term_power;
			cmd_word_q.coef  <= term_coef;
		end
	end

	assign push.valid = cmd_valid_q;
	assign push.word  = cmd_word_q;

endmodule

/* design/pam_queue.sv */
// Short command queue between front and back ends.
// Lets the front keep accepting while the back runs or waits on the output. Depends on pam_pkg.
module pam_queue import pam_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_push_t push,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output cmd_word_t head
);

	cmd_word_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push.word;
	end

endmodule

/* design/pam_back.sv */
// Back end: holds polynomials A and B, runs add and multiply and drives the result channel.
// Multiply uses a row of NUM_TERMS multipliers feeding a sliding accumulator window.
// Depends on pam_pkg.
module pam_back import pam_pkg::*; #(
	parameter int NUM_TERMS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	input  cmd_word_t               cmd_word,
	output logic                    cmd_pop,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [RPOW_W-1:0]       result_power,
	output logic signed [RES_W-1:0] result_coef,
	output logic                    last_term
);

	localparam int AW = $clog2(NUM_TERMS);
	localparam logic [RPOW_W-1:0] LAST_ADD = RPOW_W'(NUM_TERMS - 1);
	localparam logic [RPOW_W-1:0] LAST_MUL = RPOW_W'(2 * NUM_TERMS - 2);
	localparam logic [RPOW_W-1:0] TERMS    = RPOW_W'(NUM_TERMS);

	back_state_t state_q, state_d;
	logic [RPOW_W-1:0] cnt_q;
	logic              mul_q;
	logic              start;
	logic              issue;
	logic              adv;
	logic [RPOW_W-1:0] last_cnt;

	logic signed [COEF_W-1:0] a_q [NUM_TERMS];
	logic signed [COEF_W-1:0] b_q [NUM_TERMS];
	logic signed [COEF_W-1:0] b_sel;
	logic signed [SUM_W-1:0]  sum_d;

	logic                     v_s1;
	logic                     mul_s1;
	logic                     last_s1;
	logic [RPOW_W-1:0]        pow_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [PROD_W-1:0] prod_s1 [NUM_TERMS];

	logic signed [RES_W-1:0]  win_q   [NUM_TERMS];
	logic signed [RES_W-1:0]  win_new [NUM_TERMS];

	logic                     result_valid_q;
	logic [RPOW_W-1:0]        result_power_q;
	logic signed [RES_W-1:0]  result_coef_q;
	logic                     last_term_q;

	assign adv      = !result_valid_q || !result_stall;
	assign last_cnt = mul_q ? LAST_MUL : LAST_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		start   = 1'b0;
		issue   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd_word.kind == CMD_ADD || cmd_word.kind == CMD_MUL) begin
						start   = 1'b1;
						state_d = BK_RUN;
					end
				end
			end
			BK_RUN: begin
				if (adv) begin
					issue = 1'b1;
					if (cnt_q == last_cnt)
						state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			mul_q <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			mul_q <= (cmd_word.kind == CMD_MUL);
		end else if (issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TERMS; i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
			end
		end else if (cmd_pop) begin
			case (cmd_word.kind)
				CMD_CLR_A: for (int i = 0; i < NUM_TERMS; i++) a_q[i] <= '0;
				CMD_CLR_B: for (int i = 0; i < NUM_TERMS; i++) b_q[i] <= '0;
				CMD_WR_A: a_q[cmd_word.power[AW-1:0]] <= cmd_word.coef;
				CMD_WR_B: b_q[cmd_word.power[AW-1:0]] <= cmd_word.coef;
				default: ;
			endcase
		end
	end

	assign b_sel = (cnt_q < TERMS) ? b_q[cnt_q[AW-1:0]] : '0;
	assign sum_d = SUM_W'(a_q[cnt_q[AW-1:0]]) + SUM_W'(b_q[cnt_q[AW-1:0]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mul_s1  <= mul_q;
			last_s1 <= (cnt_q == last_cnt);
			pow_s1  <= cnt_q;
			sum_s1  <= sum_d;
			for (int i = 0; i < NUM_TERMS; i++)
				prod_s1[i] <= PROD_W'(a_q[i]) * PROD_W'(b_sel);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_TERMS; i++)
			win_new[i] = ((pow_s1 == '0) ? '0 : win_q[i]) + RES_W'(prod_s1[i]);
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && mul_s1) begin
			for (int i = 0; i < NUM_TERMS - 1; i++)
				win_q[i] <= win_new[i + 1];
			win_q[NUM_TERMS - 1] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (adv)
			result_valid_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			result_power_q <= pow_s1;
			result_coef_q  <= mul_s1 ? win_new[0] : RES_W'(sum_s1);
			last_term_q    <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result_power = result_power_q;
	assign result_coef  = result_coef_q;
	assign last_term    = last_term_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for polynomial_add_multiply_core: clear, term write, add, multiply and unused-opcode
// words with a local model of both polynomials that predicts every sum and product term.
// Depends on pam_pkg and the core RTL only.
module testbench;
	import pam_pkg::*;

	localparam int NUM_TERMS   = 32;
	localparam int PHASE_WORDS = 65;
	localparam int HOLD_CYCLES = 400;
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;
	localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;

	typedef struct {
		logic [OP_W-1:0]           op;
		logic [POW_W-1:0]          power;
		logic signed [COEF_W-1:0]  coef;
	} word_in_t;

	typedef struct {
		logic [RPOW_W-1:0]         power;
		logic signed [RES_W-1:0]   coef;
		logic                      last;
	} result_term_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [OP_W-1:0] opcode = '0;
	logic [POW_W-1:0] term_power = '0;
	logic signed [COEF_W-1:0] term_coef = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [RPOW_W-1:0] result_power;
	logic signed [RES_W-1:0] result_coef;
	logic last_term;

	word_in_t queued_words[$];
	result_term_t due_terms[$];
	logic signed [COEF_W-1:0] coef_a[NUM_TERMS];
	logic signed [COEF_W-1:0] coef_b[NUM_TERMS];
	word_in_t next_word;
	int words_queued = 0;
	int fault_count = 0;
	int sender_idle_pct = 9;
	int receiver_idle_pct = 50;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;

	polynomial_add_multiply_core #(.NUM_TERMS(NUM_TERMS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.term_power   (term_power),
		.term_coef    (term_coef),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_power (result_power),
		.result_coef  (result_coef),
		.last_term    (last_term)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#8_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void compute_terms(word_in_t w);
		longint conv[2*NUM_TERMS-1];
		longint acc;
		result_term_t t;
		case (w.op)
			OP_CLR_A: foreach (coef_a[i]) coef_a[i] = '0;
			OP_CLR_B: foreach (coef_b[i]) coef_b[i] = '0;
			OP_WR_A: if (w.power < NUM_TERMS) coef_a[w.power] = w.coef;
			OP_WR_B: if (w.power < NUM_TERMS) coef_b[w.power] = w.coef;
			OP_ADD: begin
				for (int i = 0; i < NUM_TERMS; i++) begin
					acc = longint'(coef_a[i]) + longint'(coef_b[i]);
					t.power = RPOW_W'(i);
					t.coef = acc[RES_W-1:0];
					t.last = (i == NUM_TERMS - 1);
					due_terms.push_back(t);
				end
			end
			OP_MUL: begin
				foreach (conv[k]) conv[k] = 0;
				for (int i = 0; i < NUM_TERMS; i++)
					for (int j = 0; j < NUM_TERMS; j++)
						conv[i+j] += longint'(coef_a[i]) * longint'(coef_b[j]);
				for (int k = 0; k < 2*NUM_TERMS-1; k++) begin
					t.power = RPOW_W'(k);
					t.coef = conv[k][RES_W-1:0];
					t.last = (k == 2*NUM_TERMS - 2);
					due_terms.push_back(t);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_term();
		result_term_t want;
		if (due_terms.size() == 0) begin
			if (fault_count < 10)
				$display("%0t: unexpected result power %0d coef %0d last %0b",
					$realtime, result_power, result_coef, last_term);
			fault_count++;
		end else begin
			want = due_terms.pop_front();
			if (result_power !== want.power || result_coef !== want.coef
					|| last_term !== want.last) begin
				if (fault_count < 10)
					$display("%0t: mismatch want power %0d coef %0d last %0b, got %0d %0d %0b",
						$realtime, want.power, want.coef, want.last,
						result_power, result_coef, last_term);
				fault_count++;
			end
		end
	endfunction

	// driver: advance to the next queued word once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				compute_terms('{opcode, term_power, term_coef});
			if (!item_valid || !item_stall) begin
				if (queued_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_word = queued_words.pop_front();
					item_valid <= 1'b1;
					opcode <= next_word.op;
					term_power <= next_word.power;
					term_coef <= next_word.coef;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each taken word, hold off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_term();
			if (holds_done != hold_requests) begin
				holds_done <= hold_requests;
				hold_left <= HOLD_CYCLES;
				result_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	function automatic logic signed [COEF_W-1:0] pick_coef();
		case ($urandom_range(7))
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return '0;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic push_word(logic [OP_W-1:0] op, logic [POW_W-1:0] power,
			logic signed [COEF_W-1:0] coef);
		queued_words.push_back('{op, power, coef});
		words_queued++;
	endtask

	task automatic push_op(logic [OP_W-1:0] op);
		push_word(op, POW_W'($urandom), COEF_W'($urandom));
	endtask

	task automatic push_random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			if ($urandom_range(9) < 3)
				push_op($urandom_range(1) ? OP_CLR_A : OP_CLR_B);
			repeat ($urandom_range(1, 10))
				push_word($urandom_range(1) ? OP_WR_A : OP_WR_B, POW_W'($urandom_range(31)),
					pick_coef());
			push_op($urandom_range(1) ? OP_ADD : OP_MUL);
		end else begin
			push_op(OP_W'($urandom_range(7)));
		end
	endtask

	task automatic wait_drained();
		while (queued_words.size() != 0 || item_valid || due_terms.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic signed [COEF_W-1:0] fill_a;
		logic signed [COEF_W-1:0] fill_b;
		int phase_end;
		foreach (coef_a[i]) coef_a[i] = '0;
		foreach (coef_b[i]) coef_b[i] = '0;

		push_op(OP_CLR_A);
		push_op(OP_CLR_B);
		push_op(OP_ADD);
		push_op(OP_MUL);
		push_word(OP_WR_A, 5'd0, COEF_MAX);
		push_word(OP_WR_A, 5'd31, COEF_MIN);
		push_word(OP_WR_B, 5'd0, COEF_MIN);
		push_word(OP_WR_B, 5'd31, COEF_MAX);
		push_word(OP_WR_A, 5'd5, 16'sd100);
		push_word(OP_WR_A, 5'd5, -16'sd1);
		push_word(OP_WR_B, 5'd5, '0);
		push_op(OP_SPARE_6);
		push_op(OP_SPARE_7);
		push_op(OP_ADD);
		push_op(OP_MUL);
		push_word(OP_WR_A, 5'd0, COEF_MIN);
		push_word(OP_WR_B, 5'd0, COEF_MIN);
		push_op(OP_MUL);
		push_op(OP_CLR_A);
		push_op(OP_ADD);
		push_op(OP_MUL);
		push_op(OP_CLR_B);
		push_op(OP_ADD);

		phase_end = words_queued + PHASE_WORDS;
		while (words_queued < phase_end - 40)
			push_random_sequence();
		while (queued_words.size() > 4)
			@(negedge clk);
		hold_requests++;
		repeat (8) begin
			push_word(OP_WR_A, POW_W'($urandom_range(31)), pick_coef());
			push_op($urandom_range(1) ? OP_ADD : OP_MUL);
		end
		while (words_queued < phase_end)
			push_random_sequence();
		wait_drained();

		sender_idle_pct = 50;
		receiver_idle_pct = 9;
		phase_end = words_queued + PHASE_WORDS;
		while (words_queued < phase_end)
			push_random_sequence();
		wait_drained();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		phase_end = words_queued + PHASE_WORDS;
		fill_a = $urandom_range(1) ? COEF_MAX : COEF_MIN;
		fill_b = $urandom_range(1) ? COEF_MAX : COEF_MIN;
		for (int p = 0; p < NUM_TERMS; p++) begin
			push_word(OP_WR_A, POW_W'(p), fill_a);
			push_word(OP_WR_B, POW_W'(p), fill_b);
		end
		push_op(OP_ADD);
		push_op(OP_MUL);
		while (words_queued < phase_end)
			push_random_sequence();
		wait_drained();

		repeat (2*NUM_TERMS + 8) @(negedge clk);
		if (fault_count == 0 && due_terms.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
